FILE: hw/rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared codes, constants and the result type of the chunk index checker.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

	localparam logic [63:0] MAGIC_INDEX   = 64'h96824d9c7b129ff9;
	localparam logic [63:0] MAGIC_TABLE   = 64'he75b9e112f17417d;
	localparam logic [63:0] MAGIC_TAIL    = 64'h4b4f050e5549ecd1;
	localparam logic [63:0] FLAGS_ALLOWED = 64'hd000000000000000;
	localparam logic [63:0] HDR_BYTES     = 64'h30;

	localparam int unsigned TABLE_HDR_LEN   = 16;
	localparam int unsigned TABLE_ENTRY_LEN = 40;

	// Expected footer size is held narrow: 16 + (n + 1) * 40 fits in 38 bits.
	localparam int unsigned SIZE_W = 38;
	localparam logic [SIZE_W-1:0] SIZE_BASE = SIZE_W'(TABLE_HDR_LEN + TABLE_ENTRY_LEN);

	localparam logic [1:0] KIND_ENTRY  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [3:0] ERR_NONE        = 4'd0;
	localparam logic [3:0] ERR_INDEX_MAGIC = 4'd1;
	localparam logic [3:0] ERR_HDR_SHORT   = 4'd2;
	localparam logic [3:0] ERR_FLAGS       = 4'd3;
	localparam logic [3:0] ERR_TABLE_MAGIC = 4'd4;
	localparam logic [3:0] ERR_ZERO_FILL   = 4'd5;
	localparam logic [3:0] ERR_OFFSET      = 4'd6;
	localparam logic [3:0] ERR_SIZE        = 4'd7;
	localparam logic [3:0] ERR_TAIL        = 4'd8;

	localparam logic [1:0] WARN_NONE  = 2'd0;
	localparam logic [1:0] WARN_SHORT = 2'd1;
	localparam logic [1:0] WARN_BIG   = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  error_code;
		logic [63:0] chunk_start;
		logic [31:0] chunk_len;
		logic [63:0] id_word0;
		logic [63:0] id_word1;
		logic [63:0] id_word2;
		logic [63:0] id_word3;
		logic [1:0]  size_warning;
		logic [63:0] chunk_min;
		logic [63:0] chunk_avg;
		logic [63:0] chunk_max;
	} res_t;

	typedef struct packed {
		logic ready;
	} res_hs_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csc_parse.sv
// ----------------------------------------------------------------------------
// csc_parse
// Input register and the parsing state machine; produces at most one result
// per word, handed to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_parse (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [63:0]     file_word,
	input  wire logic            cfg_we,
	input  wire logic [31:0]     cfg_data,
	input  wire csc_pkg::res_hs_t hs_in,
	output logic                 res_load,
	output csc_pkg::res_t        res_d
);
	import csc_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TABLE,
		PH_ENTRIES,
		PH_FOOTER,
		PH_IDLE
	} phase_t;

	logic              valid_s1;
	logic [63:0]       word_s1;
	phase_t            phase_q, phase_d;
	logic [2:0]        pos_q, pos_d;
	logic [31:0]       count_q;
	logic [SIZE_W-1:0] exp_size_q;
	logic [31:0]       seen_q, seen_d;
	logic [63:0]       prev_end_q, prev_end_d;
	logic [63:0]       entry_end_q, entry_end_d;
	logic [63:0]       id_hold_q [3];
	logic              id_we;
	logic [1:0]        id_idx;
	logic              hdr_short_q, hdr_short_d;
	logic [63:0]       min_q, min_d;
	logic [63:0]       avg_q, avg_d;
	logic [63:0]       max_q, max_d;
	logic              step;
	logic              accept;
	logic              emit;
	logic [63:0]       len;
	logic              last;
	logic [32:0]       seen_inc;

	assign in_stall = valid_s1 && !hs_in.ready;
	assign accept   = in_valid && !in_stall;
	assign step     = valid_s1 && hs_in.ready;
	assign res_load = step && emit;

	assign len      = entry_end_q - prev_end_q;
	assign seen_inc = {1'b0, seen_q} + 33'd1;
	assign last     = seen_inc >= {1'b0, count_q};
	assign id_idx   = pos_q[1:0] - 2'd1;

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		seen_d      = seen_q;
		prev_end_d  = prev_end_q;
		entry_end_d = entry_end_q;
		hdr_short_d = hdr_short_q;
		min_d       = min_q;
		avg_d       = avg_q;
		max_d       = max_q;
		id_we       = 1'b0;
		emit        = 1'b0;
		res_d       = '0;
		unique case (phase_q)
			PH_HEADER: begin
				pos_d = pos_q + 3'd1;
				unique case (pos_q)
					3'd0: hdr_short_d = word_s1 < HDR_BYTES;
					3'd1: begin
						if (word_s1 != MAGIC_INDEX) begin
							emit             = 1'b1;
							res_d.error_code = ERR_INDEX_MAGIC;
						end else if (hdr_short_q) begin
							emit             = 1'b1;
							res_d.error_code = ERR_HDR_SHORT;
						end
					end
					3'd2: begin
						if ((word_s1 & ~FLAGS_ALLOWED) != 64'd0) begin
							emit             = 1'b1;
							res_d.error_code = ERR_FLAGS;
						end
					end
					3'd3: min_d = word_s1;
					3'd4: avg_d = word_s1;
					default: begin
						max_d           = word_s1;
						emit            = 1'b1;
						res_d.kind      = KIND_HEADER;
						res_d.chunk_min = min_q;
						res_d.chunk_avg = avg_q;
						res_d.chunk_max = word_s1;
						phase_d         = PH_TABLE;
						pos_d           = 3'd0;
					end
				endcase
			end
			PH_TABLE: begin
				if (pos_q == 3'd0) begin
					pos_d = 3'd1;
				end else if (word_s1 != MAGIC_TABLE) begin
					emit             = 1'b1;
					res_d.error_code = ERR_TABLE_MAGIC;
				end else begin
					phase_d = (count_q != 32'd0) ? PH_ENTRIES : PH_FOOTER;
					pos_d   = 3'd0;
				end
			end
			PH_ENTRIES: begin
				unique case (pos_q)
					3'd0: begin
						entry_end_d = word_s1;
						pos_d       = 3'd1;
					end
					3'd1, 3'd2, 3'd3: begin
						id_we = 1'b1;
						pos_d = pos_q + 3'd1;
					end
					default: begin
						pos_d  = 3'd0;
						seen_d = seen_inc[31:0];
						if (last) begin
							phase_d = PH_FOOTER;
						end
						if (len[63:32] == 32'd0) begin
							emit              = 1'b1;
							res_d.kind        = KIND_ENTRY;
							res_d.chunk_start = prev_end_q;
							res_d.chunk_len   = len[31:0];
							res_d.id_word0    = id_hold_q[0];
							res_d.id_word1    = id_hold_q[1];
							res_d.id_word2    = id_hold_q[2];
							res_d.id_word3    = word_s1;
							if ((len < min_q) && !last) begin
								res_d.size_warning = WARN_SHORT;
							end else if (len > max_q) begin
								res_d.size_warning = WARN_BIG;
							end
							prev_end_d = entry_end_q;
						end
					end
				endcase
			end
			PH_FOOTER: begin
				pos_d = pos_q + 3'd1;
				unique case (pos_q)
					3'd0, 3'd1: begin
						if (word_s1 != 64'd0) begin
							emit             = 1'b1;
							res_d.error_code = ERR_ZERO_FILL;
						end
					end
					3'd2: begin
						if (word_s1 != HDR_BYTES) begin
							emit             = 1'b1;
							res_d.error_code = ERR_OFFSET;
						end
					end
					3'd3: begin
						if (word_s1 != {{(64-SIZE_W){1'b0}}, exp_size_q}) begin
							emit             = 1'b1;
							res_d.error_code = ERR_SIZE;
						end
					end
					default: begin
						emit = 1'b1;
						if (word_s1 != MAGIC_TAIL) begin
							res_d.error_code = ERR_TAIL;
						end else begin
							res_d.kind = KIND_DONE;
							phase_d    = PH_IDLE;
							pos_d      = 3'd0;
						end
					end
				endcase
			end
			default: begin
				pos_d = pos_q;
			end
		endcase
		if (res_d.error_code != ERR_NONE) begin
			res_d.kind = KIND_ERROR;
			phase_d    = PH_IDLE;
			pos_d      = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			word_s1      <= '0;
			phase_q      <= PH_HEADER;
			pos_q        <= '0;
			count_q      <= '0;
			exp_size_q   <= SIZE_BASE;
			seen_q       <= '0;
			prev_end_q   <= '0;
			entry_end_q  <= '0;
			id_hold_q[0] <= '0;
			id_hold_q[1] <= '0;
			id_hold_q[2] <= '0;
			hdr_short_q  <= 1'b0;
			min_q        <= '0;
			avg_q        <= '0;
			max_q        <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				word_s1  <= file_word;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_we) begin
				count_q    <= cfg_data;
				exp_size_q <= SIZE_W'({cfg_data, 5'd0}) + SIZE_W'({cfg_data, 3'd0})
					+ SIZE_BASE;
				phase_q    <= PH_HEADER;
				pos_q      <= '0;
				seen_q     <= '0;
				prev_end_q <= '0;
			end else if (step) begin
				phase_q     <= phase_d;
				pos_q       <= pos_d;
				seen_q      <= seen_d;
				prev_end_q  <= prev_end_d;
				entry_end_q <= entry_end_d;
				hdr_short_q <= hdr_short_d;
				min_q       <= min_d;
				avg_q       <= avg_d;
				max_q       <= max_d;
				if (id_we) begin
					id_hold_q[id_idx] <= word_s1;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/csc_outreg.sv
// ----------------------------------------------------------------------------
// csc_outreg
// Result register; holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_outreg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            res_load,
	input  wire csc_pkg::res_t   res_d,
	input  wire logic            out_stall,
	output logic                 out_valid,
	output csc_pkg::res_hs_t     hs_out,
	output csc_pkg::res_t        res_q
);
	import csc_pkg::*;

	logic valid_q;

	assign out_valid    = valid_q;
	assign hs_out.ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/chunk_index_stream_checker.sv
// ----------------------------------------------------------------------------
// chunk_index_stream_checker
// Parses a chunk index file word by word and reports header sizes, chunk
// entries, completion and numbered errors.
//
//   channel  direction  handshake            payload
//   in       receive    in_valid/in_stall    file_word
//   out      send       out_valid/out_stall  kind .. chunk_max
//   cfg      receive    cfg_valid/cfg_ready  entry_count
//
// One word is taken every cycle while in_stall is low; a taken word waits in the
// input register, and its result, if any, is loaded into the result register.
// The rate is set by the single parsing step between the input register and
// the result register. Reset is asynchronous and restarts at the header.
// A stalled result holds the input side only once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_index_stream_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] file_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] entry_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [3:0]       error_code,
	output logic [63:0]      chunk_start,
	output logic [31:0]      chunk_len,
	output logic [63:0]      id_word0,
	output logic [63:0]      id_word1,
	output logic [63:0]      id_word2,
	output logic [63:0]      id_word3,
	output logic [1:0]       size_warning,
	output logic [63:0]      chunk_min,
	output logic [63:0]      chunk_avg,
	output logic [63:0]      chunk_max
);
	import csc_pkg::*;

	res_t    res_d;
	res_t    res_q;
	res_hs_t hs;
	logic    res_load;

	assign cfg_ready = 1'b1;

	csc_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.file_word(file_word),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (entry_count),
		.hs_in    (hs),
		.res_load (res_load),
		.res_d    (res_d)
	);

	csc_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res_d    (res_d),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.hs_out   (hs),
		.res_q    (res_q)
	);

	assign kind         = res_q.kind;
	assign error_code   = res_q.error_code;
	assign chunk_start  = res_q.chunk_start;
	assign chunk_len    = res_q.chunk_len;
	assign id_word0     = res_q.id_word0;
	assign id_word1     = res_q.id_word1;
	assign id_word2     = res_q.id_word2;
	assign id_word3     = res_q.id_word3;
	assign size_warning = res_q.size_warning;
	assign chunk_min    = res_q.chunk_min;
	assign chunk_avg    = res_q.chunk_avg;
	assign chunk_max    = res_q.chunk_max;

endmodule

`default_nettype wire

FILE: hw/rtl/csc_checker.sv
// ----------------------------------------------------------------------------
// csc_checker
// Port-level assertions for the chunk index checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  kind,
	input wire logic [3:0]  error_code,
	input wire logic [31:0] chunk_len,
	input wire logic [1:0]  size_warning
);
	import csc_pkg::*;

	// A stalled result beat keeps its kind and code.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(error_code))
		else $error("stalled result beat changed");

	// The input side is held back only by a blocked result.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// Error beats carry a known nonzero code, other beats carry none.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_ERROR) ==
			(error_code != ERR_NONE && error_code <= ERR_TAIL))
		else $error("error code does not match result kind");

	// Only chunk entry beats carry a length or a size warning.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ENTRY |-> chunk_len == 32'd0 && size_warning == WARN_NONE)
		else $error("entry fields set on a non-entry beat");

	// A size warning is one of the three defined values.
	a_warn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> size_warning == WARN_NONE || size_warning == WARN_SHORT ||
			size_warning == WARN_BIG)
		else $error("undefined size warning");

endmodule

bind chunk_index_stream_checker csc_checker u_csc_checker (.*);

`default_nettype wire

FILE: tb/csc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_result_checker
// Watches the word, count and result channels of the chunk index checker.
// It parses every accepted word with its own copy of the parser state, keeps
// the records that the words must produce in order, and compares each result
// beat field by field with the oldest of them.
// ----------------------------------------------------------------------------

module csc_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] file_word,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] entry_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  error_code,
	input  logic [63:0] chunk_start,
	input  logic [31:0] chunk_len,
	input  logic [63:0] id_word0,
	input  logic [63:0] id_word1,
	input  logic [63:0] id_word2,
	input  logic [63:0] id_word3,
	input  logic [1:0]  size_warning,
	input  logic [63:0] chunk_min,
	input  logic [63:0] chunk_avg,
	input  logic [63:0] chunk_max,
	output int          mismatches,
	output int          due_count
);
	import csc_pkg::*;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_TABLE,
		ST_ENTRIES,
		ST_FOOTER,
		ST_IDLE
	} stage_t;

	stage_t      stage;
	int unsigned word_pos;
	logic [31:0] cfg_entries;
	logic [31:0] seen;
	logic [63:0] prev_end;
	logic [63:0] end_hold;
	logic [63:0] len_hold;
	logic [63:0] lo_bound;
	logic [63:0] avg_hold;
	logic [63:0] hi_bound;
	logic [63:0] id_hold [0:2];
	res_t        records_due [$];
	int          fails;

	initial begin
		mismatches = 0;
		due_count = 0;
		fails = 0;
	end

	task automatic restart_parse();
		stage = ST_HEADER;
		word_pos = 0;
		seen = '0;
		prev_end = '0;
	endtask

	task automatic raise_error(input logic [3:0] code);
		res_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		records_due.push_back(r);
		stage = ST_IDLE;
		word_pos = 0;
	endtask

	task automatic parse_word(input logic [63:0] w);
		res_t        r;
		logic [63:0] len;
		logic [63:0] size_due;
		logic [31:0] seen_next;
		logic        last;
		r = '0;
		case (stage)
			ST_HEADER: begin
				case (word_pos)
					0: begin
						len_hold = w;
						word_pos++;
					end
					1: begin
						if (w != MAGIC_INDEX) raise_error(ERR_INDEX_MAGIC);
						else if (len_hold < HDR_BYTES) raise_error(ERR_HDR_SHORT);
						else word_pos++;
					end
					2: begin
						if ((w & ~FLAGS_ALLOWED) != '0) raise_error(ERR_FLAGS);
						else word_pos++;
					end
					3: begin
						lo_bound = w;
						word_pos++;
					end
					4: begin
						avg_hold = w;
						word_pos++;
					end
					default: begin
						hi_bound = w;
						r.kind = KIND_HEADER;
						r.chunk_min = lo_bound;
						r.chunk_avg = avg_hold;
						r.chunk_max = hi_bound;
						records_due.push_back(r);
						stage = ST_TABLE;
						word_pos = 0;
					end
				endcase
			end
			ST_TABLE: begin
				if (word_pos == 0) begin
					word_pos = 1;
				end else if (w != MAGIC_TABLE) begin
					raise_error(ERR_TABLE_MAGIC);
				end else begin
					stage = (cfg_entries != '0) ? ST_ENTRIES : ST_FOOTER;
					word_pos = 0;
				end
			end
			ST_ENTRIES: begin
				if (word_pos == 0) begin
					end_hold = w;
					word_pos = 1;
				end else if (word_pos < 4) begin
					id_hold[2'(word_pos - 1)] = w;
					word_pos++;
				end else begin
					len = end_hold - prev_end;
					seen_next = seen + 32'd1;
					last = (seen_next >= cfg_entries);
					word_pos = 0;
					seen = seen_next;
					if (seen >= cfg_entries) stage = ST_FOOTER;
					if (len[63:32] == '0) begin
						r.kind = KIND_ENTRY;
						r.chunk_start = prev_end;
						r.chunk_len = len[31:0];
						r.id_word0 = id_hold[0];
						r.id_word1 = id_hold[1];
						r.id_word2 = id_hold[2];
						r.id_word3 = w;
						if (len < lo_bound && !last) r.size_warning = WARN_SHORT;
						else if (len > hi_bound) r.size_warning = WARN_BIG;
						else r.size_warning = WARN_NONE;
						records_due.push_back(r);
						prev_end = end_hold;
					end
				end
			end
			ST_FOOTER: begin
				size_due = 64'(TABLE_HDR_LEN) + (64'(cfg_entries) + 64'd1) * 64'(TABLE_ENTRY_LEN);
				case (word_pos)
					0, 1: begin
						if (w != '0) raise_error(ERR_ZERO_FILL);
						else word_pos++;
					end
					2: begin
						if (w != HDR_BYTES) raise_error(ERR_OFFSET);
						else word_pos++;
					end
					3: begin
						if (w != size_due) raise_error(ERR_SIZE);
						else word_pos++;
					end
					default: begin
						if (w != MAGIC_TAIL) begin
							raise_error(ERR_TAIL);
						end else begin
							r.kind = KIND_DONE;
							records_due.push_back(r);
							stage = ST_IDLE;
							word_pos = 0;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fails++;
		end
	endtask

	task automatic check_beat();
		res_t want;
		if (records_due.size() == 0) begin
			$display("%0t: result beat with nothing expected, kind expected none, actual %0d",
				$time, kind);
			fails++;
		end else begin
			want = records_due.pop_front();
			check_field("kind", 64'(want.kind), 64'(kind));
			check_field("error_code", 64'(want.error_code), 64'(error_code));
			check_field("chunk_start", want.chunk_start, chunk_start);
			check_field("chunk_len", 64'(want.chunk_len), 64'(chunk_len));
			check_field("id_word0", want.id_word0, id_word0);
			check_field("id_word1", want.id_word1, id_word1);
			check_field("id_word2", want.id_word2, id_word2);
			check_field("id_word3", want.id_word3, id_word3);
			check_field("size_warning", 64'(want.size_warning), 64'(size_warning));
			check_field("chunk_min", want.chunk_min, chunk_min);
			check_field("chunk_avg", want.chunk_avg, chunk_avg);
			check_field("chunk_max", want.chunk_max, chunk_max);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_entries = '0;
			restart_parse();
			records_due.delete();
		end else begin
			if (out_valid && !out_stall) check_beat();
			if (cfg_valid && cfg_ready) begin
				cfg_entries = entry_count;
				restart_parse();
			end
			if (in_valid && !in_stall) parse_word(file_word);
		end
		due_count <= records_due.size();
		mismatches <= fails;
	end

endmodule

FILE: tb/chunk_index_stream_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_index_stream_checker_tb
// Feeds the chunk index checker with index files: a few directed files for
// the extreme header values and the error order, then random files that are
// mostly well formed, with one flaw in some of them and truncated tables in
// others. Sender gaps and receiver stalls vary from file to file, and one file
// runs against a long receiver hold-off. Results are checked by a separate
// checker instance.
// ----------------------------------------------------------------------------

module chunk_index_stream_checker_tb;
	import csc_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 64;
	localparam int WORD_TARGET = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] file_word = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] entry_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  error_code;
	logic [63:0] chunk_start;
	logic [31:0] chunk_len;
	logic [63:0] id_word0;
	logic [63:0] id_word1;
	logic [63:0] id_word2;
	logic [63:0] id_word3;
	logic [1:0]  size_warning;
	logic [63:0] chunk_min;
	logic [63:0] chunk_avg;
	logic [63:0] chunk_max;

	int          mismatches;
	int          due_count;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_req = 0;
	int          quiet = 0;
	logic [63:0] file_words [$];
	int          file_items;

	always #6 clk = ~clk;

	chunk_index_stream_checker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.file_word   (file_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.entry_count (entry_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.error_code  (error_code),
		.chunk_start (chunk_start),
		.chunk_len   (chunk_len),
		.id_word0    (id_word0),
		.id_word1    (id_word1),
		.id_word2    (id_word2),
		.id_word3    (id_word3),
		.size_warning(size_warning),
		.chunk_min   (chunk_min),
		.chunk_avg   (chunk_avg),
		.chunk_max   (chunk_max)
	);

	csc_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.file_word   (file_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.entry_count (entry_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.error_code  (error_code),
		.chunk_start (chunk_start),
		.chunk_len   (chunk_len),
		.id_word0    (id_word0),
		.id_word1    (id_word1),
		.id_word2    (id_word2),
		.id_word3    (id_word3),
		.size_warning(size_warning),
		.chunk_min   (chunk_min),
		.chunk_avg   (chunk_avg),
		.chunk_max   (chunk_max),
		.mismatches  (mismatches),
		.due_count   (due_count)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] flip_bit();
		return 64'd1 << $urandom_range(0, 63);
	endfunction

	function automatic void build_file(input logic [31:0] count, input int n,
			input logic [3:0] flaw);
		logic [63:0] prev;
		logic [63:0] stop;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] w;
		int          cut;
		int          zero_pick;
		int          bad_bit;
		cut = -1;
		file_words.delete();
		case ($urandom_range(0, 3))
			0: w = HDR_BYTES;
			1: w = '1;
			default: w = rand64() | 64'h40;
		endcase
		if (flaw == ERR_HDR_SHORT) w = 64'($urandom_range(0, 47));
		file_words.push_back(w);
		if (flaw == ERR_HDR_SHORT || flaw == ERR_INDEX_MAGIC) cut = 2;
		file_words.push_back(flaw == ERR_INDEX_MAGIC ? MAGIC_INDEX ^ flip_bit() : MAGIC_INDEX);
		w = rand64() & FLAGS_ALLOWED;
		if (flaw == ERR_FLAGS) begin
			bad_bit = $urandom_range(0, 60);
			if (bad_bit == 60) bad_bit = 61;
			w |= 64'd1 << bad_bit;
			cut = 3;
		end
		file_words.push_back(w);
		case ($urandom_range(0, 7))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: begin
				lo = '1;
				hi = '0;
			end
			default: begin
				lo = 64'($urandom_range(0, 1200));
				hi = 64'($urandom_range(800, 3000));
			end
		endcase
		file_words.push_back(lo);
		file_words.push_back(rand64());
		file_words.push_back(hi);
		file_words.push_back(rand64());
		if (flaw == ERR_TABLE_MAGIC) cut = 8;
		file_words.push_back(flaw == ERR_TABLE_MAGIC ? MAGIC_TABLE ^ flip_bit() : MAGIC_TABLE);
		prev = '0;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: stop = prev + 64'hFFFF_FFFF;
				1: stop = prev + 64'h1_0000_0000 + 64'($urandom);
				2: stop = rand64();
				default: stop = prev + 64'($urandom_range(0, 4000));
			endcase
			file_words.push_back(stop);
			repeat (4) file_words.push_back(rand64());
			if (stop - prev <= 64'hFFFF_FFFF) prev = stop;
		end
		if (64'(count) == 64'(n)) begin
			zero_pick = $urandom_range(0, 1);
			for (int z = 0; z < 2; z++) begin
				if (flaw == ERR_ZERO_FILL && z == zero_pick) begin
					cut = file_words.size() + 1;
					file_words.push_back(flip_bit());
				end else begin
					file_words.push_back('0);
				end
			end
			if (flaw == ERR_OFFSET) cut = file_words.size() + 1;
			file_words.push_back(flaw == ERR_OFFSET ? HDR_BYTES ^ flip_bit() : HDR_BYTES);
			w = 64'(TABLE_HDR_LEN) + (64'(count) + 64'd1) * 64'(TABLE_ENTRY_LEN);
			if (flaw == ERR_SIZE) begin
				cut = file_words.size() + 1;
				w ^= flip_bit();
			end
			file_words.push_back(w);
			if (flaw == ERR_TAIL) cut = file_words.size() + 1;
			file_words.push_back(flaw == ERR_TAIL ? MAGIC_TAIL ^ flip_bit() : MAGIC_TAIL);
		end
		if (cut < 0) begin
			file_items = file_words.size();
		end else begin
			file_items = cut;
			while (file_words.size() > cut) void'(file_words.pop_back());
		end
		repeat ($urandom_range(0, 3)) file_words.push_back(rand64());
	endfunction

	task automatic push_word(input logic [63:0] w);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		file_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_words.size(); i++) push_word(file_words[i]);
	endtask

	task automatic drain(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_count(input logic [31:0] value);
		drain(6);
		cfg_valid <= 1'b1;
		entry_count <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The receiver stalls at random, or holds off for a long stretch on request.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int          items;
		int          fidx;
		int          n;
		logic [31:0] count;
		logic [3:0]  flaw;
		items = 0;
		fidx = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_count('0);
		file_words = '{'1, MAGIC_INDEX, FLAGS_ALLOWED, '0, '1, '1, '0, MAGIC_TABLE,
			'0, '0, HDR_BYTES, 64'(TABLE_HDR_LEN + TABLE_ENTRY_LEN), MAGIC_TAIL,
			rand64(), rand64()};
		send_file();
		write_count('1);
		file_words = '{64'h2F, MAGIC_INDEX};
		send_file();
		write_count(32'd3);
		file_words = '{64'h2F, ~MAGIC_INDEX};
		send_file();

		while (items < WORD_TARGET) begin
			case ((fidx / 2) % 5)
				1: begin
					idle_pct = 87;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 87;
				end
				3: begin
					idle_pct = 31;
					stall_pct = 31;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			n = $urandom_range(0, 6);
			count = 32'(n);
			flaw = ($urandom_range(0, 9) < 3) ? 4'($urandom_range(1, 8)) : ERR_NONE;
			if (fidx == 2) begin
				n = 14;
				count = 32'(n);
				flaw = ERR_NONE;
				idle_pct = 0;
				stall_pct = 0;
			end else if ($urandom_range(0, 11) == 0) begin
				count = $urandom_range(0, 1) ? '1 : ($urandom | 32'h100);
			end
			write_count(count);
			build_file(count, n, flaw);
			if (fidx == 2) hold_req++;
			send_file();
			items += file_items;
			fidx++;
		end

		drain(12);
		if (mismatches == 0 && due_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: chunk_index_stream_checker.f
hw/rtl/csc_pkg.sv
hw/rtl/csc_parse.sv
hw/rtl/csc_outreg.sv
hw/rtl/chunk_index_stream_checker.sv
hw/rtl/csc_checker.sv
tb/csc_result_checker.sv
tb/chunk_index_stream_checker_tb.sv
